/* design/sursel_pkg.sv */
`default_nettype none

package sursel_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned NUM_CONTROLS_DEF = 8;
  localparam int unsigned FRAC_BITS_DEF    = 16;

  // Fixed field widths
  localparam int unsigned NUM_FRAC_PORTS = 8;
  localparam int unsigned SIZE_W         = 16;
  localparam int unsigned FRAC_W         = 17;
  localparam int unsigned CNT_W          = 4;
  localparam int unsigned IDX_W          = 3;
  localparam int unsigned RES_W          = 48;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 17;

  typedef logic signed [RES_W-1:0] res_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_USE_VANISHING = 2'd0,
    CFG_ZERO_TOL      = 2'd1,
    CFG_CTRL_COUNT    = 2'd2
  } cfg_idx_e;

  // Per-beat strobes from the sequencer to every lane
  typedef struct packed {
    logic mul;
    logic add;
    logic clr;
    logic sub;
  } lane_ctrl_t;

  // Outcome of the selection stage
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } sel_res_t;

endpackage

`default_nettype wire

/* design/sum_up_rounding_selector_unit.sv */
// Sum-up rounding selector: one input beat per mesh cell, one result beat
// per input beat.
//
// Input channel (in_valid_i / in_ready_o) carries first_cell, the cell length
// and eight Q1.16 fractions. Output channel (out_valid_o / out_ready_i) carries
// the chosen control index and the none_eligible flag. Configuration is a
// separate write channel (cfg_valid_i / cfg_ready_o, index and data); it is
// always ready and must only be used while no cell is in flight.
//
// Each cell passes through the multiply, accumulate, select and reduce steps
// in turn, and its result is registered as the reduce step finishes. A new
// beat is taken only once the sequencer is back in idle, so cells do not
// overlap; the residual feedback through the select stage calls for this.
//
// Reset clears every residual, empties the output register and sets the
// registers to vanishing off, tolerance zero and eight controls in use.
// If the receiver stalls, the result is held in the output register; one
// further cell is taken and worked up to its reduce step, where it waits
// until the held beat has been taken.

`default_nettype none

module sum_up_rounding_selector_unit import sursel_pkg::*; #(
  parameter int unsigned NUM_CONTROLS = NUM_CONTROLS_DEF,
  parameter int unsigned FRAC_BITS    = FRAC_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write channel
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // input channel
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  first_cell_i,
  input  wire logic [SIZE_W-1:0]     mesh_len_i,
  input  wire logic [FRAC_W-1:0]     frac_0_i,
  input  wire logic [FRAC_W-1:0]     frac_1_i,
  input  wire logic [FRAC_W-1:0]     frac_2_i,
  input  wire logic [FRAC_W-1:0]     frac_3_i,
  input  wire logic [FRAC_W-1:0]     frac_4_i,
  input  wire logic [FRAC_W-1:0]     frac_5_i,
  input  wire logic [FRAC_W-1:0]     frac_6_i,
  input  wire logic [FRAC_W-1:0]     frac_7_i,
  // output channel
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [IDX_W-1:0]           chosen_control_o,
  output logic                       none_eligible_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ADD  = 5'b00100,
    ST_SEL  = 5'b01000,
    ST_SUB  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic             use_van_q;
  logic [FRAC_W-1:0] tol_q;
  logic [CNT_W-1:0] cnt_q;

  // Captured input beat
  logic              first_q;
  logic [SIZE_W-1:0] size_q;
  logic [FRAC_W-1:0] frac_q [NUM_FRAC_PORTS];

  // Output register
  logic             out_valid_q;
  logic [IDX_W-1:0] chosen_q;
  logic             none_q;

  logic in_fire, out_free, sub_fire;

  lane_ctrl_t              lane_ctrl;
  res_t                    residual [NUM_CONTROLS];
  logic [FRAC_W-1:0]       frac_lane [NUM_CONTROLS];
  logic [NUM_CONTROLS-1:0] win;
  sel_res_t                sel;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  // The reduce step may only finish when the output register can take the beat
  assign out_free    = !out_valid_q || out_ready_i;
  assign sub_fire    = (state_q == ST_SUB) && out_free;

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_van_q <= 1'b0;
      tol_q     <= '0;
      cnt_q     <= CNT_W'(8);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_USE_VANISHING: use_van_q <= cfg_data_i[0];
        CFG_ZERO_TOL:      tol_q     <= cfg_data_i[FRAC_W-1:0];
        CFG_CTRL_COUNT:    cnt_q     <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the accepted beat for the whole cell
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      first_q   <= first_cell_i;
      size_q    <= mesh_len_i;
      frac_q[0] <= frac_0_i;
      frac_q[1] <= frac_1_i;
      frac_q[2] <= frac_2_i;
      frac_q[3] <= frac_3_i;
      frac_q[4] <= frac_4_i;
      frac_q[5] <= frac_5_i;
      frac_q[6] <= frac_6_i;
      frac_q[7] <= frac_7_i;
    end
  end

  // Sequencer: advance one step a cycle; wait in idle for a beat, hold in reduce while the output is full
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_MUL;
      ST_MUL:  state_d = ST_ADD;
      ST_ADD:  state_d = ST_SEL;
      ST_SEL:  state_d = ST_SUB;
      ST_SUB:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign lane_ctrl.mul = (state_q == ST_MUL);
  assign lane_ctrl.add = (state_q == ST_ADD);
  assign lane_ctrl.clr = first_q;
  assign lane_ctrl.sub = sub_fire;

  // One lane per control: multiply, accumulate, reduce when chosen
  for (genvar g = 0; g < NUM_CONTROLS; g++) begin : g_lane
    assign frac_lane[g] = frac_q[g];

    sursel_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (lane_ctrl),
      .size_i     (size_q),
      .frac_i     (frac_lane[g]),
      .win_i      (win[g]),
      .residual_o (residual[g])
    );
  end

  // Merge the lanes: largest eligible residual, lower index on a tie
  sursel_merge #(
    .NUM_CONTROLS (NUM_CONTROLS)
  ) u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (state_q == ST_SEL),
    .res_i     (residual),
    .frac_i    (frac_lane),
    .use_van_i (use_van_q),
    .tol_i     (tol_q),
    .cnt_i     (cnt_q),
    .win_o     (win),
    .sel_o     (sel)
  );

  // Output register: load on the reduce step, drop once the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sub_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sub_fire) begin
      chosen_q <= sel.found ? sel.idx : '0;
      none_q   <= !sel.found;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign chosen_control_o = chosen_q;
  assign none_eligible_o  = none_q;

  // At most one lane may be reduced per cell
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(win))
    else $error("more than one lane selected");

  // The found flag must agree with the lane selection
  assert property (@(posedge clk_i) disable iff (!rst_ni) sel.found == (|win))
    else $error("found flag disagrees with lane selection");

  // A fresh result beat only ever follows a reduce step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $rose(out_valid_q) |-> $past(state_q == ST_SUB))
    else $error("result raised outside the reduce step");

  // A cell with no eligible control reports control zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && none_q) |-> (chosen_q == '0))
    else $error("none_eligible with non-zero index");

endmodule

`default_nettype wire

/* design/sursel_lane.sv */
`default_nettype none

module sursel_lane import sursel_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lane_ctrl_t        ctrl_i,
  input  wire logic [SIZE_W-1:0] size_i,
  input  wire logic [FRAC_W-1:0] frac_i,
  input  wire logic              win_i,
  output res_t                   residual_o
);

  localparam int unsigned PROD_W = SIZE_W + FRAC_W;
  localparam int unsigned DEC_W  = SIZE_W + FRAC_BITS;

  // Clamp a one-bit-wider result to the residual range
  function automatic res_t sat_res(input logic [RES_W:0] v);
    res_t r;
    if (v[RES_W] != v[RES_W-1]) begin
      r = v[RES_W] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
    end else begin
      r = v[RES_W-1:0];
    end
    return r;
  endfunction

  logic [PROD_W-1:0] prod_q;
  res_t              residual_q, residual_d;
  res_t              base;
  logic [RES_W:0]    sum, diff;
  logic [DEC_W-1:0]  decr;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      prod_q <= PROD_W'(size_i) * PROD_W'(frac_i);
    end
  end

  always_comb begin
    base       = ctrl_i.clr ? '0 : residual_q;
    sum        = {base[RES_W-1], base} + (RES_W+1)'(prod_q);
    decr       = {size_i, {FRAC_BITS{1'b0}}};
    diff       = {residual_q[RES_W-1], residual_q} - (RES_W+1)'(decr);
    residual_d = residual_q;
    if (ctrl_i.add) begin
      residual_d = sat_res(sum);
    end else if (ctrl_i.sub && win_i) begin
      residual_d = sat_res(diff);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      residual_q <= '0;
    end else begin
      residual_q <= residual_d;
    end
  end

  assign residual_o = residual_q;

endmodule

`default_nettype wire

/* design/sursel_merge.sv */
`default_nettype none

module sursel_merge import sursel_pkg::*; #(
  parameter int unsigned NUM_CONTROLS = NUM_CONTROLS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire res_t                    res_i  [NUM_CONTROLS],
  input  wire logic [FRAC_W-1:0]       frac_i [NUM_CONTROLS],
  input  wire logic                    use_van_i,
  input  wire logic [FRAC_W-1:0]       tol_i,
  input  wire logic [CNT_W-1:0]        cnt_i,
  output logic [NUM_CONTROLS-1:0]      win_o,
  output sel_res_t                     sel_o
);

  logic [CNT_W-1:0]        cnt_eff;
  logic [NUM_CONTROLS-1:0] elig, win_d, win_q;
  sel_res_t                sel_d, sel_q;

  // Pairwise compares: a lane wins when it beats every eligible lower lane
  // and no eligible higher lane beats it
  always_comb begin
    cnt_eff = cnt_i;
    if (cnt_i < CNT_W'(2)) begin
      cnt_eff = CNT_W'(2);
    end else if (cnt_i > CNT_W'(NUM_CONTROLS)) begin
      cnt_eff = CNT_W'(NUM_CONTROLS);
    end
    for (int i = 0; i < NUM_CONTROLS; i++) begin
      elig[i] = (CNT_W'(i) < cnt_eff) && !(use_van_i && (frac_i[i] <= tol_i));
    end
    sel_d = '0;
    for (int i = 0; i < NUM_CONTROLS; i++) begin
      win_d[i] = elig[i];
      for (int j = 0; j < NUM_CONTROLS; j++) begin
        if (j < i) begin
          win_d[i] = win_d[i] & (!elig[j] | (res_i[i] > res_i[j]));
        end else if (j > i) begin
          win_d[i] = win_d[i] & (!elig[j] | !(res_i[j] > res_i[i]));
        end
      end
      if (win_d[i]) begin
        sel_d.idx = sel_d.idx | IDX_W'(i);
      end
    end
    sel_d.found = |win_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      sel_q <= '0;
    end else if (en_i) begin
      win_q <= win_d;
      sel_q <= sel_d;
    end
  end

  assign win_o = win_q;
  assign sel_o = sel_q;

endmodule

`default_nettype wire

/* test/sursel_checker.sv */
// Watches the configuration, cell and result channels of the selector,
// keeps its own copy of the residuals and registers, and checks every
// result beat against the oldest expected pick.
module sursel_checker import sursel_pkg::*; (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  input  logic                                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]                  cfg_index_i,
  input  logic [CFG_DATA_W-1:0]                 cfg_data_i,
  input  logic                                  in_valid_i,
  input  logic                                  in_ready_i,
  input  logic                                  first_cell_i,
  input  logic [SIZE_W-1:0]                     mesh_len_i,
  input  logic [NUM_FRAC_PORTS-1:0][FRAC_W-1:0] frac_i,
  input  logic                                  out_valid_i,
  input  logic                                  out_ready_i,
  input  logic [IDX_W-1:0]                      chosen_control_i,
  input  logic                                  none_eligible_i,
  output int unsigned                           fail_count_o,
  output int unsigned                           pending_o,
  output int unsigned                           results_o,
  output int unsigned                           idle_results_o
);

  localparam longint RES_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint RES_LO = -RES_HI - 1;

  typedef struct packed {
    logic [IDX_W-1:0] chosen;
    logic             none;
  } pick_t;

  res_t              resid [NUM_FRAC_PORTS];
  logic              vanish_q;
  logic [FRAC_W-1:0] tol_q;
  logic [CNT_W-1:0]  count_q;
  pick_t             picks_due [$];

  task automatic note_mismatch(string msg);
    $display("%0t: mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  function automatic res_t clamp48(longint v);
    if (v > RES_HI) return res_t'(RES_HI);
    if (v < RES_LO) return res_t'(RES_LO);
    return res_t'(v);
  endfunction

  // Advance the residuals by one cell and return the pick it causes.
  function automatic pick_t round_cell(logic first, logic [SIZE_W-1:0] size,
                                       logic [NUM_FRAC_PORTS-1:0][FRAC_W-1:0] frac);
    longint sz;
    int     n;
    int     best;
    bit     found;
    pick_t  p;
    sz    = longint'(size);
    n     = int'(count_q);
    best  = 0;
    found = 1'b0;
    if (n < 2) n = 2;
    if (n > int'(NUM_FRAC_PORTS)) n = int'(NUM_FRAC_PORTS);
    if (first) foreach (resid[i]) resid[i] = '0;
    foreach (resid[i]) resid[i] = clamp48(longint'(resid[i]) + sz * longint'(frac[i]));
    for (int i = 0; i < n; i++) begin
      if (vanish_q && frac[i] <= tol_q) continue;
      if (!found || resid[i] > resid[best]) begin
        found = 1'b1;
        best  = i;
      end
    end
    if (found) begin
      resid[best] = clamp48(longint'(resid[best]) - (sz << FRAC_BITS_DEF));
      p.chosen    = IDX_W'(best);
      p.none      = 1'b0;
    end else begin
      p.chosen = '0;
      p.none   = 1'b1;
    end
    return p;
  endfunction

  always @(posedge clk_i) begin
    pick_t due;
    if (!rst_ni) begin
      foreach (resid[i]) resid[i] = '0;
      vanish_q       = 1'b0;
      tol_q          = '0;
      count_q        = CNT_W'(8);
      picks_due      = {};
      fail_count_o   = 0;
      results_o      = 0;
      idle_results_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_USE_VANISHING: vanish_q = cfg_data_i[0];
          CFG_ZERO_TOL:      tol_q    = cfg_data_i[FRAC_W-1:0];
          CFG_CTRL_COUNT:    count_q  = cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
      // results first: a beat taken at this edge cannot answer a cell
      // taken at the same edge
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (none_eligible_i) idle_results_o++;
        if (picks_due.size() == 0) begin
          note_mismatch($sformatf("unexpected result: control %0d none_eligible %0b",
                                  chosen_control_i, none_eligible_i));
        end else begin
          due = picks_due.pop_front();
          if (chosen_control_i !== due.chosen)
            note_mismatch($sformatf("chosen_control %0d, expected %0d",
                                    chosen_control_i, due.chosen));
          if (none_eligible_i !== due.none)
            note_mismatch($sformatf("none_eligible %0b, expected %0b",
                                    none_eligible_i, due.none));
        end
      end
      if (in_valid_i && in_ready_i)
        picks_due = {picks_due, round_cell(first_cell_i, mesh_len_i, frac_i)};
    end
    pending_o = picks_due.size();
  end

endmodule

/* test/sum_up_rounding_selector_unit_tb.sv */
// Top of the selector testbench: makes the clock, reset, cell and
// configuration beats and the result back-pressure, and gives the verdict.
// All prediction and comparison lives in sursel_checker.
module sum_up_rounding_selector_unit_tb;
  import sursel_pkg::*;

  localparam int unsigned SOAK_CELLS    = 40;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  // register index beyond the three defined ones: writes must have no effect
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
  localparam logic [FRAC_W-1:0]    FRAC_ONE      = 17'd65536;
  localparam logic [FRAC_W-1:0]    FRAC_TOP      = '1;
  localparam logic [SIZE_W-1:0]    SIZE_TOP      = '1;

  typedef struct packed {
    logic                                  first;
    logic [SIZE_W-1:0]                     size;
    logic [NUM_FRAC_PORTS-1:0][FRAC_W-1:0] frac;
  } cell_t;

  logic                                  clk;
  logic                                  rst_n;
  logic                                  cfg_valid;
  logic                                  cfg_ready;
  logic [CFG_IDX_W-1:0]                  cfg_index;
  logic [CFG_DATA_W-1:0]                 cfg_data;
  logic                                  in_valid;
  logic                                  in_ready;
  logic                                  first_cell;
  logic [SIZE_W-1:0]                     mesh_len;
  logic [NUM_FRAC_PORTS-1:0][FRAC_W-1:0] frac;
  logic                                  out_valid;
  logic                                  out_ready;
  logic [IDX_W-1:0]                      chosen_control;
  logic                                  none_eligible;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned results_seen;
  int unsigned idle_results;

  // Stimulus bookkeeping: the tolerance in force steers fractions towards
  // the vanishing threshold; idle_on gates gaps and stalls on both sides.
  bit                idle_on = 1'b1;
  logic [FRAC_W-1:0] tol_set = '0;
  int unsigned       cells_sent;
  int unsigned       settings_used;

  sum_up_rounding_selector_unit dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .first_cell_i     (first_cell),
    .mesh_len_i       (mesh_len),
    .frac_0_i         (frac[0]),
    .frac_1_i         (frac[1]),
    .frac_2_i         (frac[2]),
    .frac_3_i         (frac[3]),
    .frac_4_i         (frac[4]),
    .frac_5_i         (frac[5]),
    .frac_6_i         (frac[6]),
    .frac_7_i         (frac[7]),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .chosen_control_o (chosen_control),
    .none_eligible_o  (none_eligible)
  );

  sursel_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .first_cell_i     (first_cell),
    .mesh_len_i       (mesh_len),
    .frac_i           (frac),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .chosen_control_i (chosen_control),
    .none_eligible_i  (none_eligible),
    .fail_count_o     (mismatches),
    .pending_o        (pending),
    .results_o        (results_seen),
    .idle_results_o   (idle_results)
  );

  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly no gap, now and then a short one, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return SIZE_TOP;
    if (r < 50) return SIZE_W'($urandom_range(1, 255));
    return SIZE_W'($urandom_range(0, 65535));
  endfunction

  // Raw fraction: zero, exactly one, hugging the tolerance, above one,
  // tiny or anywhere from zero to one.
  function automatic logic [FRAC_W-1:0] noise_frac();
    int unsigned r;
    int          t;
    r = $urandom_range(0, 99);
    if (r < 20) return '0;
    if (r < 30) return FRAC_ONE;
    if (r < 45) begin
      t = int'(tol_set) + int'($urandom_range(0, 4)) - 2;
      if (t < 0) t = 0;
      if (t > int'(FRAC_TOP)) t = int'(FRAC_TOP);
      return FRAC_W'(t);
    end
    if (r < 52) return FRAC_W'($urandom_range(65537, 131071));
    if (r < 65) return FRAC_W'($urandom_range(1, 255));
    return FRAC_W'($urandom_range(0, 65536));
  endfunction

  function automatic cell_t noise_cell();
    cell_t c;
    c.first = ($urandom_range(0, 9) == 0);
    c.size  = pick_size();
    foreach (c.frac[i]) c.frac[i] = noise_frac();
    return c;
  endfunction

  // Well-formed relaxed controls: fractions summing to exactly one, with
  // the mass scattered from a random starting control.
  function automatic cell_t tidy_cell(logic first);
    cell_t       c;
    int unsigned left;
    int unsigned shift;
    int unsigned v;
    c.first = first;
    c.size  = pick_size();
    left    = 65536;
    shift   = $urandom_range(0, NUM_FRAC_PORTS - 1);
    for (int i = 0; i < NUM_FRAC_PORTS - 1; i++) begin
      v    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, left);
      c.frac[(i + shift) % NUM_FRAC_PORTS] = FRAC_W'(v);
      left -= v;
    end
    c.frac[(NUM_FRAC_PORTS - 1 + shift) % NUM_FRAC_PORTS] = FRAC_W'(left);
    return c;
  endfunction

  function automatic cell_t flat_cell(logic first, logic [SIZE_W-1:0] size,
                                      logic [FRAC_W-1:0] val);
    cell_t c;
    c.first = first;
    c.size  = size;
    foreach (c.frac[i]) c.frac[i] = val;
    return c;
  endfunction

  // One control carries val, the rest are zero.
  function automatic cell_t spike_cell(logic first, logic [SIZE_W-1:0] size,
                                       int unsigned idx, logic [FRAC_W-1:0] val);
    cell_t c;
    c          = flat_cell(first, size, '0);
    c.frac[idx] = val;
    return c;
  endfunction

  // Offer one cell beat; hold valid and payload until it is taken. Valid
  // only drops when a gap is wanted, so back-to-back beats keep it high.
  task automatic push_cell(cell_t c);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    first_cell = c.first;
    mesh_len   = c.size;
    frac       = c.frac;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    cells_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Drop valid, let every expected result come back, then let the
  // pipeline settle before touching the registers.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all three registers; spare data bits carry noise that the
  // block must mask off.
  task automatic apply_setting(logic van, logic [FRAC_W-1:0] tol, logic [CNT_W-1:0] cnt);
    logic [CFG_DATA_W-1:0] word;
    wait_idle();
    word    = CFG_DATA_W'($urandom);
    word[0] = van;
    write_reg(CFG_USE_VANISHING, word);
    write_reg(CFG_ZERO_TOL, tol);
    word             = CFG_DATA_W'($urandom);
    word[CNT_W-1:0]  = cnt;
    write_reg(CFG_CTRL_COUNT, word);
    tol_set = tol;
    settings_used++;
  endtask

  // Runs of well-formed cells, each run opening a fresh mesh, with about a
  // quarter raw noise mixed in; noise can break a run or clear it midway.
  // With fresh low the first run carries on from the residuals left behind.
  task automatic run_meshes(int unsigned cells, logic fresh);
    int unsigned done;
    int unsigned run_len;
    logic        head;
    done = 0;
    head = fresh;
    while (done < cells) begin
      run_len = $urandom_range(4, 60);
      for (int k = 0; k < run_len && done < cells; k++) begin
        if ($urandom_range(0, 3) == 0) push_cell(noise_cell());
        else push_cell(tidy_cell((k == 0) ? head : 1'b0));
        done++;
      end
      head = 1'b1;
    end
  endtask

  // Drive controls two to seven at full size and the largest fraction with
  // only two controls in use: nothing reduces them, so their residuals grow
  // large. Run flat out to keep the cycle count down.
  task automatic soak_saturation();
    cell_t c;
    idle_on = 1'b0;
    for (int unsigned k = 0; k < SOAK_CELLS; k++) begin
      c.first = (k == 0);
      c.size  = SIZE_TOP;
      foreach (c.frac[i])
        c.frac[i] = (i < 2) ? FRAC_W'($urandom_range(0, 65536)) : FRAC_TOP;
      push_cell(c);
    end
    idle_on = 1'b1;
  endtask

  // Result side: random stalls of the same shape as the cell gaps.
  initial begin : result_sink
    int unsigned stall;
    out_ready = 1'b0;
    stall     = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else begin
        out_ready = 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) stall = pick_gap();
      end
    end
  end

  initial begin : stimulus
    int unsigned waited;
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_USE_VANISHING;
    cfg_data   = '0;
    in_valid   = 1'b0;
    first_cell = 1'b0;
    mesh_len   = '0;
    frac       = '0;
    cells_sent    = 0;
    settings_used = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed cells on the reset defaults: vanishing off, tolerance zero,
    // eight controls. Full ties must go to control 0.
    push_cell(flat_cell(1'b1, '0, '0));
    push_cell(flat_cell(1'b1, SIZE_TOP, FRAC_ONE));
    push_cell(flat_cell(1'b0, SIZE_TOP, FRAC_TOP));
    push_cell(spike_cell(1'b0, 16'd1, 7, FRAC_ONE));

    // Vanishing with zero tolerance: all-zero fractions leave nothing
    // eligible; the smallest non-zero fraction wins on its own.
    apply_setting(1'b1, '0, 4'd8);
    push_cell(flat_cell(1'b1, 16'd100, '0));
    push_cell(spike_cell(1'b0, 16'd100, 5, 17'd1));

    // Tolerance at one: a fraction equal to it vanishes, one above does not.
    apply_setting(1'b1, FRAC_ONE, 4'd8);
    push_cell(flat_cell(1'b1, 16'd300, FRAC_ONE));
    push_cell(spike_cell(1'b0, 16'd300, 3, FRAC_ONE + 17'd1));

    // Control count of zero acts as two: control 4 accumulates but is never
    // picked.
    apply_setting(1'b0, FRAC_TOP, 4'd0);
    push_cell(spike_cell(1'b1, 16'd50, 4, FRAC_ONE));
    push_cell(spike_cell(1'b0, 16'd50, 1, FRAC_ONE));

    // Control count of fifteen acts as eight.
    apply_setting(1'b1, 17'd1000, 4'd15);
    push_cell(spike_cell(1'b1, SIZE_TOP, 7, 17'd1001));
    push_cell(spike_cell(1'b0, SIZE_TOP, 6, 17'd1000));

    // Write to the unused register index must change nothing.
    wait_idle();
    write_reg(CFG_SPARE_IDX, '1);
    push_cell(flat_cell(1'b0, 16'd7, 17'd2000));

    // Random meshes across a spread of settings; one phase runs without
    // any gaps or stalls.
    apply_setting(1'b0, '0, 4'd8);
    run_meshes(200, 1'b1);
    apply_setting(1'b1, '0, 4'd8);
    run_meshes(200, 1'b1);
    apply_setting(1'b1, FRAC_ONE, 4'd2);
    idle_on = 1'b0;
    run_meshes(150, 1'b1);
    idle_on = 1'b1;
    apply_setting(1'b1, FRAC_W'($urandom_range(0, 3000)), CNT_W'($urandom_range(0, 15)));
    run_meshes(200, 1'b1);
    apply_setting(1'b0, FRAC_TOP, 4'd1);
    run_meshes(150, 1'b1);

    // Build up large residuals, then pick among them without clearing them.
    apply_setting(1'b0, '0, 4'd2);
    soak_saturation();
    apply_setting(1'b0, FRAC_W'($urandom_range(0, 65536)), 4'd8);
    run_meshes(200, 1'b0);
    apply_setting(1'b1, 17'd200, 4'd9);
    run_meshes(150, 1'b1);

    // Drain: wait for every expected result, with a limit, then a few
    // quiet cycles to catch any stray beat.
    @(negedge clk);
    in_valid = 1'b0;
    waited   = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending != 0) $display("%0d results never arrived", pending);

    $display("Run covered %0d cells over %0d register settings, incl. a %0d-cell soak",
             cells_sent, settings_used, SOAK_CELLS);
    $display("%0d results checked, %0d with no eligible control, %0d mismatches",
             results_seen, idle_results, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin : watchdog
    #20_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("Verification failed");
    $finish;
  end

endmodule

/* sum_up_rounding_selector_unit.f */
design/sursel_pkg.sv
design/sursel_lane.sv
design/sursel_merge.sv
design/sum_up_rounding_selector_unit.sv
test/sursel_checker.sv
test/sum_up_rounding_selector_unit_tb.sv
